// File: hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion with asynchronous reset disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion checked also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/glpb_pkg.sv
// package: constants, opcodes and state encoding for the bisection core
package glpb_pkg;
	localparam int MaxVertices   = 1024;
	localparam int MaxAdjEntries = 8192;
	localparam int OpW  = 3;
	localparam int IdxW = 13;
	localparam int ValW = 14;
	localparam int CntW = 11;
	localparam int SwpW = 16;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;

	typedef enum logic [OpW-1:0] {
		OP_WR_ROW  = 3'd0,
		OP_WR_ADJ  = 3'd1,
		OP_WR_SIDE = 3'd2,
		OP_RUN     = 3'd3,
		OP_READ    = 3'd4
	} opcode_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_VERTEX_COUNT  = 2'd0,
		CFG_SWEEP_COUNT   = 2'd1,
		CFG_BALANCE_LIMIT = 2'd2
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDWAIT,
		ST_CNT_RD,
		ST_CNT_ACC,
		ST_V_START,
		ST_V_ROW0,
		ST_V_ROW1,
		ST_V_ROW2,
		ST_V_EDGE,
		ST_V_EDGE_WAIT,
		ST_V_SIDE_WAIT,
		ST_V_DECIDE,
		ST_RESP
	} state_t;
endpackage

// File: hw/rtl/glpb_if.sv
// valid/ready channel interfaces for items and results
interface glpb_in_if #(parameter int IdxW = 13, parameter int ValW = 14);
	logic valid;
	logic ready;
	logic [2:0] opcode;
	logic [IdxW-1:0] index;
	logic [ValW-1:0] value;
	modport source(output valid, opcode, index, value, input ready);
	modport sink(input valid, opcode, index, value, output ready);
endinterface

interface glpb_out_if #(parameter int CntW = 11);
	logic valid;
	logic ready;
	logic part_bit;
	logic [CntW-1:0] size_zero;
	logic [CntW-1:0] size_one;
	logic index_error;
	modport source(output valid, part_bit, size_zero, size_one, index_error, input ready);
	modport sink(input valid, part_bit, size_zero, size_one, index_error, output ready);
endinterface

// File: hw/rtl/glpb_ram.sv
// generic single-port synchronous ram with registered read
module glpb_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: hw/rtl/greedy_label_propagation_bisection_core.sv
// Greedy label-propagation bisection core. A load or read item passes through the accept,
// one ram access, the result register, then the result transaction.
// No new item is taken while a result waits. A run item first counts the sides. Each sweep
// then visits every vertex: one whose flip is not blocked reads its row offsets and the side
// of each neighbour, a blocked one skips the neighbour scan. The single-port side and adjacency
// memories serialize every neighbour lookup. Runs stop early after a sweep with no flip.
// No clearing pass: the stores are undefined until written.
module greedy_label_propagation_bisection_core
	import glpb_pkg::*;
#(
	parameter int MAX_VERTICES    = MaxVertices,
	parameter int MAX_ADJ_ENTRIES = MaxAdjEntries
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	glpb_in_if.sink             in_ch,
	glpb_out_if.source          out_ch
);
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int RW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_ADJ_ENTRIES);
	localparam int OW = $clog2(MAX_ADJ_ENTRIES + 1);
	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [CntW-1:0] vcount_q, blim_q, cz_q, co_q;
	logic [SwpW-1:0] sweeps_q, swp_q;
	state_t st_q, st_d;

	logic row_we, adj_we, side_we;
	logic [RW-1:0] row_addr;
	logic [AW-1:0] adj_addr;
	logic [VW-1:0] side_addr;
	logic [OW-1:0] row_wd, row_rd;
	logic [VW-1:0] adj_wd, adj_rd;
	logic side_wd, side_rd;

	glpb_ram #(.Width(OW), .Depth(MAX_VERTICES + 1)) u_row (
		.clk, .we(row_we), .addr(row_addr), .wdata(row_wd), .rdata(row_rd));
	glpb_ram #(.Width(VW), .Depth(MAX_ADJ_ENTRIES)) u_adj (
		.clk, .we(adj_we), .addr(adj_addr), .wdata(adj_wd), .rdata(adj_rd));
	glpb_ram #(.Width(1), .Depth(MAX_VERTICES)) u_side (
		.clk, .we(side_we), .addr(side_addr), .wdata(side_wd), .rdata(side_rd));

	logic [OpW-1:0]  op_q;
	logic [IdxW-1:0] idx_q;
	logic [ValW-1:0] val_q;
	logic [NW-1:0]   n_q, v_q;
	logic [OW-1:0]   k_q, last_q;
	logic            cur_q, changed_q;
	logic [OW-1:0]   onz_q, ono_q;
	logic            ovalid_q, obit_q, oerr_q;

	logic in_fire;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (st_q == ST_IDLE) && !ovalid_q;

	logic [IdxW:0] idx_x;
	logic [ValW:0] val_x;
	assign idx_x = {1'b0, idx_q};
	assign val_x = {1'b0, val_q};
	logic err_c;
	always_comb begin
		case (op_q)
			OP_WR_ROW:  err_c = idx_x > (IdxW+1)'(MAX_VERTICES) ||
				val_x > (ValW+1)'(MAX_ADJ_ENTRIES);
			OP_WR_ADJ:  err_c = idx_x >= (IdxW+1)'(MAX_ADJ_ENTRIES) ||
				val_x >= (ValW+1)'(MAX_VERTICES);
			OP_WR_SIDE: err_c = idx_x >= (IdxW+1)'(MAX_VERTICES) || val_q > ValW'(1);
			OP_READ:    err_c = idx_x >= (IdxW+1)'(MAX_VERTICES);
			default:    err_c = 1'b0;
		endcase
	end

	logic target;
	logic [CntW-1:0] tsize;
	logic [OW:0] on_t, on_s;
	assign target = ~cur_q;
	assign tsize = target ? co_q : cz_q;
	assign on_t = target ? {1'b0, ono_q} : {1'b0, onz_q};
	assign on_s = target ? {1'b0, onz_q} : {1'b0, ono_q};

	always_comb begin
		st_d = st_q;
		row_we = 1'b0; adj_we = 1'b0; side_we = 1'b0;
		row_addr = RW'(idx_q);
		adj_addr = AW'(idx_q);
		side_addr = VW'(idx_q);
		row_wd = OW'(val_q);
		adj_wd = VW'(val_q);
		side_wd = val_q[0];
		case (st_q)
			ST_IDLE: if (in_fire) st_d = ST_RDWAIT;
			ST_RDWAIT: begin
				// op registered; perform write or launch read
				case (op_q)
					OP_WR_ROW:  begin row_we = !err_c; st_d = ST_RESP; end
					OP_WR_ADJ:  begin adj_we = !err_c; st_d = ST_RESP; end
					OP_WR_SIDE: begin side_we = !err_c; st_d = ST_RESP; end
					OP_READ:    st_d = ST_RESP;
					OP_RUN:     st_d = (n_q == '0) ? ST_RESP : ST_CNT_RD;
					default:    st_d = ST_RESP;
				endcase
			end
			ST_CNT_RD: begin side_addr = VW'(v_q); st_d = ST_CNT_ACC; end
			ST_CNT_ACC: begin
				side_addr = VW'(v_q);
				if (v_q + NW'(1) == n_q)
					st_d = (swp_q == '0) ? ST_RESP : ST_V_START;
				else st_d = ST_CNT_RD;
			end
			ST_V_START: begin side_addr = VW'(v_q); st_d = ST_V_ROW0; end
			ST_V_ROW0: begin
				side_addr = VW'(v_q);
				row_addr = RW'(v_q);
				st_d = ST_V_ROW1;
			end
			ST_V_ROW1: begin
				// cur_q valid now; blocked flips skip
				row_addr = RW'(v_q + NW'(1));
				if (tsize > blim_q) st_d = ST_V_DECIDE;
				else begin
					side_we = 1'b1; side_addr = VW'(v_q); side_wd = target;
					st_d = ST_V_ROW2;
				end
			end
			ST_V_ROW2: begin
				row_addr = RW'(v_q + NW'(1));
				st_d = ST_V_EDGE;
			end
			ST_V_EDGE: begin
				adj_addr = AW'(k_q);
				st_d = (k_q < last_q) ? ST_V_EDGE_WAIT : ST_V_DECIDE;
			end
			ST_V_EDGE_WAIT: begin
				side_addr = adj_rd;
				st_d = ST_V_SIDE_WAIT;
			end
			ST_V_SIDE_WAIT: st_d = ST_V_EDGE;
			ST_V_DECIDE: begin
				side_addr = VW'(v_q);
				if (!(tsize > blim_q) && !(on_s < on_t)) begin
					side_we = 1'b1; side_wd = cur_q;
				end
				if (v_q + NW'(1) == n_q) begin
					if (swp_q == SwpW'(1) || !(changed_q || (!(tsize > blim_q) && on_s < on_t)))
						st_d = ST_RESP;
					else st_d = ST_V_START;
				end else st_d = ST_V_START;
			end
			ST_RESP: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	logic [OW-1:0] first_c;
	assign first_c = row_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			vcount_q <= '0; sweeps_q <= SwpW'(1); blim_q <= CntW'(512);
			cz_q <= '0; co_q <= '0; ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_VERTEX_COUNT:  vcount_q <= CntW'(cfg_data);
					CFG_SWEEP_COUNT:   sweeps_q <= cfg_data;
					CFG_BALANCE_LIMIT: blim_q <= CntW'(cfg_data);
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			if (st_q == ST_RDWAIT && op_q == OP_RUN) begin
				cz_q <= '0; co_q <= '0;
			end
			if (st_q == ST_CNT_ACC) begin
				if (side_rd) co_q <= co_q + CntW'(1);
				else cz_q <= cz_q + CntW'(1);
			end
			if (st_q == ST_V_DECIDE && !(tsize > blim_q) && on_s < on_t) begin
				if (target) begin co_q <= co_q + CntW'(1); cz_q <= cz_q - CntW'(1); end
				else begin cz_q <= cz_q + CntW'(1); co_q <= co_q - CntW'(1); end
			end
			if (st_q == ST_RESP) ovalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= in_ch.opcode; idx_q <= in_ch.index; val_q <= in_ch.value;
			n_q <= (vcount_q > CntW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_q);
		end
		case (st_q)
			ST_RDWAIT: begin
				v_q <= '0; swp_q <= sweeps_q; changed_q <= 1'b0;
			end
			ST_CNT_ACC: v_q <= (v_q + NW'(1) == n_q) ? '0 : v_q + NW'(1);
			ST_V_ROW0: begin
				// side bit of the vertex arrives here
				onz_q <= '0; ono_q <= '0; cur_q <= side_rd;
			end
			// start offset of the row arrives here
			ST_V_ROW1: k_q <= first_c;
			ST_V_SIDE_WAIT: begin
				if (side_rd) ono_q <= ono_q + OW'(1);
				else onz_q <= onz_q + OW'(1);
				k_q <= k_q + OW'(1);
			end
			ST_V_DECIDE: begin
				if (v_q + NW'(1) == n_q) begin
					v_q <= '0; swp_q <= swp_q - SwpW'(1); changed_q <= 1'b0;
				end else begin
					v_q <= v_q + NW'(1);
					if (!(tsize > blim_q) && on_s < on_t) changed_q <= 1'b1;
				end
			end
			default: ;
		endcase
		if (st_q == ST_V_ROW2) begin
			// end offset arrives here, clamp to storage
			last_q <= (row_rd > OW'(MAX_ADJ_ENTRIES)) ? OW'(MAX_ADJ_ENTRIES) : row_rd;
		end
		if (st_q == ST_RESP) begin
			obit_q <= (op_q == OP_READ) && !err_c && side_rd;
			oerr_q <= err_c;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.part_bit = obit_q;
	assign out_ch.size_zero = cz_q;
	assign out_ch.size_one = co_q;
	assign out_ch.index_error = oerr_q;
endmodule

// File: hw/rtl/glpb_checker.sv
// port-level checker for the bisection core, bound into the core module
`include "assert_macros.svh"
module glpb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_part_bit,
	input logic out_index_error
);
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped")
	`ASSERT_CLK(a_no_accept_busy, clk, arst_n, out_valid |-> !in_ready, "accept with result pending")
	`ASSERT_CLK(a_bit_err, clk, arst_n, out_valid |-> !(out_part_bit && out_index_error), "bit on error")
	`ASSERT_CLK(a_acc_then_busy, clk, arst_n, in_valid && in_ready |=> !in_ready, "double accept")
endmodule

bind greedy_label_propagation_bisection_core glpb_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_part_bit(out_ch.part_bit), .out_index_error(out_ch.index_error)
);
